// File: rtl/core/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// File: rtl/core/mdh_pkg.sv
// Package with the constants, types and control program of the MD tag histogram.
package mdh_pkg;

    localparam int READ_LEN = 128;
    localparam int ADDR_W   = $clog2(READ_LEN);
    localparam int LEFT_W   = $clog2(READ_LEN + 1);
    localparam int CHAR_W   = 8;
    localparam int QPOS_W   = 7;
    localparam int CNT_W    = 32;
    localparam int RUN_W    = 16;
    localparam int POS_W    = 16;
    localparam int PROD_W   = 20;

    localparam logic [CHAR_W-1:0] CHAR_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9 = 8'h39;
    localparam logic [CNT_W-1:0]  CNT_MAX = '1;
    localparam logic [RUN_W-1:0]  RUN_MAX = '1;
    localparam logic [POS_W-1:0]  POS_MAX = '1;

    typedef enum logic [3:0] {
        S_WAIT,
        S_RD,
        S_RD_OUT,
        S_DIG,
        S_FA_INIT,
        S_FA_TEST,
        S_FA_INC,
        S_SKIP,
        S_FB_INIT,
        S_FB_TEST,
        S_FB_INC,
        S_CLOSE
    } step_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_DISPATCH,
        COND_EOT,
        COND_LEFT0,
        COND_OUT_FREE
    } cond_t;

    typedef enum logic [1:0] {
        RUN_KEEP,
        RUN_DIGIT,
        RUN_CLEAR
    } run_op_t;

    typedef enum logic [1:0] {
        POS_KEEP,
        POS_ADVANCE,
        POS_INC,
        POS_CLEAR
    } pos_op_t;

    typedef enum logic [1:0] {
        MEM_IDLE,
        MEM_RD_QUERY,
        MEM_RD_ADDR,
        MEM_WR_INC
    } mem_op_t;

    typedef struct packed {
        logic    in_rdy;
        logic    flush_init;
        logic    out_load;
        logic    rec_inc;
        run_op_t run_op;
        pos_op_t pos_op;
        mem_op_t mem_op;
        cond_t   cond;
        step_t   next;
        step_t   alt;
    } uword_t;

    function automatic uword_t ucode(step_t s);
        uword_t w;
        w = '0;
        unique case (s)
            S_WAIT:
            begin
                w.in_rdy = 1'b1;
                w.cond   = COND_DISPATCH;
                w.next   = S_WAIT;
            end
            S_RD:
            begin
                w.mem_op = MEM_RD_QUERY;
                w.next   = S_RD_OUT;
            end
            S_RD_OUT:
            begin
                w.out_load = 1'b1;
                w.cond     = COND_OUT_FREE;
                w.next     = S_WAIT;
                w.alt      = S_RD_OUT;
            end
            S_DIG:
            begin
                w.run_op = RUN_DIGIT;
                w.cond   = COND_EOT;
                w.next   = S_WAIT;
                w.alt    = S_FB_INIT;
            end
            S_FA_INIT:
            begin
                w.flush_init = 1'b1;
                w.run_op     = RUN_CLEAR;
                w.pos_op     = POS_ADVANCE;
                w.next       = S_FA_TEST;
            end
            S_FA_TEST:
            begin
                w.mem_op = MEM_RD_ADDR;
                w.cond   = COND_LEFT0;
                w.next   = S_FA_INC;
                w.alt    = S_SKIP;
            end
            S_FA_INC:
            begin
                w.mem_op = MEM_WR_INC;
                w.next   = S_FA_TEST;
            end
            S_SKIP:
            begin
                w.pos_op = POS_INC;
                w.cond   = COND_EOT;
                w.next   = S_WAIT;
                w.alt    = S_FB_INIT;
            end
            S_FB_INIT:
            begin
                w.flush_init = 1'b1;
                w.run_op     = RUN_CLEAR;
                w.pos_op     = POS_ADVANCE;
                w.next       = S_FB_TEST;
            end
            S_FB_TEST:
            begin
                w.mem_op = MEM_RD_ADDR;
                w.cond   = COND_LEFT0;
                w.next   = S_FB_INC;
                w.alt    = S_CLOSE;
            end
            S_FB_INC:
            begin
                w.mem_op = MEM_WR_INC;
                w.next   = S_FB_TEST;
            end
            S_CLOSE:
            begin
                w.rec_inc = 1'b1;
                w.run_op  = RUN_CLEAR;
                w.pos_op  = POS_CLEAR;
                w.next    = S_WAIT;
            end
            default:
            begin
                w.next = S_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

// File: rtl/core/mdh_if.sv
// Valid/ready channel interfaces for the MD tag histogram items.
interface mdh_req_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [mdh_pkg::CHAR_W-1:0]  md_char;
    logic                        end_of_tag;
    logic [mdh_pkg::QPOS_W-1:0]  query_position;

    modport source (output valid, action, md_char, end_of_tag, query_position, input ready);
    modport sink (input valid, action, md_char, end_of_tag, query_position, output ready);
endinterface

interface mdh_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [mdh_pkg::CNT_W-1:0]   position_count;
    logic [mdh_pkg::CNT_W-1:0]   record_total;

    modport source (output valid, position_count, record_total, input ready);
    modport sink (input valid, position_count, record_total, output ready);
endinterface

// File: rtl/core/mdh_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module mdh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/core/md_tag_match_histogram_core.sv
// MD tag match-position histogram: top level with microcoded control and datapath.
//
// Items enter on req: action 0 carries one MD tag character, action 1 asks for
// the match count at query_position. Readouts answer on rsp with that count and
// the number of tags completed so far; characters give no response item.
// Every item is taken in the wait step, and a digit then adds its value to the run.
// Flushing the pending run, for a non-digit and again at the end of a tag,
// sets up the flush and then counts each position with a test and an increment
// step; a non-digit then skips the mismatch base, and the end of a tag closes it.
// The counters sit in one single-port-per-direction RAM, so each position costs
// one read step and one write step. A readout reads its counter, then loads it.
// One item is worked on at a time; req.ready is high only between items.
// A response waits in an output register, so a new item may be taken while
// the receiver stalls; a second readout then waits until that register frees.
// Reset clears the run, position and tag total and marks all counters as
// zero through one valid bit per position, so the block is ready at once.
module md_tag_match_histogram_core (
    input logic      clk,
    input logic      rst_n,
    mdh_req_if.sink  req,
    mdh_rsp_if.source rsp
);

    import mdh_pkg::*;

    step_t                step_reg, step_next;
    uword_t               uw;
    logic [RUN_W-1:0]     run_reg, run_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [CNT_W-1:0]     rec_reg, rec_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [LEFT_W-1:0]    left_reg, left_next;
    logic [READ_LEN-1:0]  valid_reg, valid_next;
    logic                 out_valid_reg, out_valid_next;

    logic [CHAR_W-1:0]    char_reg;
    logic                 eot_reg;
    logic [QPOS_W-1:0]    query_reg;
    logic                 rvalid_reg;
    logic [CNT_W-1:0]     out_count_reg;
    logic [CNT_W-1:0]     out_total_reg;

    logic                 accept;
    logic                 in_digit;
    logic                 out_free;
    logic                 qry_ok;
    logic [PROD_W-1:0]    prod;
    logic [POS_W:0]       pos_sum;
    logic [POS_W-1:0]     pos_adv;
    logic [LEFT_W-1:0]    room;
    logic [LEFT_W-1:0]    flush_len;

    logic                 mem_we;
    logic                 mem_re;
    logic [ADDR_W-1:0]    mem_raddr;
    logic [CNT_W-1:0]     mem_wdata;
    logic [CNT_W-1:0]     mem_rdata;

    assign uw        = ucode(step_reg);
    assign req.ready = uw.in_rdy;
    assign accept    = req.valid && uw.in_rdy;
    assign in_digit  = (req.md_char >= CHAR_0) && (req.md_char <= CHAR_9);
    assign out_free  = !out_valid_reg || rsp.ready;
    assign qry_ok    = int'(query_reg) < READ_LEN;

    assign rsp.valid          = out_valid_reg;
    assign rsp.position_count = out_count_reg;
    assign rsp.record_total   = out_total_reg;

    // Next step of the control program.
    always_comb
    begin
        step_next = step_reg;
        unique case (uw.cond)
            COND_NEXT:
            begin
                step_next = uw.next;
            end
            COND_DISPATCH:
            begin
                if (accept)
                begin
                    priority if (req.action)
                    begin
                        step_next = S_RD;
                    end
                    else if (in_digit)
                    begin
                        step_next = S_DIG;
                    end
                    else
                    begin
                        step_next = S_FA_INIT;
                    end
                end
            end
            COND_EOT:
            begin
                step_next = eot_reg ? uw.alt : uw.next;
            end
            COND_LEFT0:
            begin
                step_next = (left_reg == '0) ? uw.alt : uw.next;
            end
            COND_OUT_FREE:
            begin
                step_next = out_free ? uw.next : uw.alt;
            end
            default:
            begin
                step_next = S_WAIT;
            end
        endcase
    end

    // Datapath driven by the control word.
    always_comb
    begin
        prod = (PROD_W'(run_reg) << 3) + (PROD_W'(run_reg) << 1)
             + PROD_W'(char_reg - CHAR_0);
        pos_sum = {1'b0, pos_reg} + {1'b0, run_reg};
        pos_adv = pos_sum[POS_W] ? POS_MAX : pos_sum[POS_W-1:0];
        room    = LEFT_W'(POS_W'(READ_LEN) - pos_reg);
        if (pos_reg >= POS_W'(READ_LEN))
        begin
            flush_len = '0;
        end
        else if (run_reg < RUN_W'(room))
        begin
            flush_len = LEFT_W'(run_reg);
        end
        else
        begin
            flush_len = room;
        end

        run_next       = run_reg;
        pos_next       = pos_reg;
        rec_next       = rec_reg;
        addr_next      = addr_reg;
        left_next      = left_reg;
        valid_next     = valid_reg;
        out_valid_next = out_valid_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_raddr      = addr_reg;
        mem_wdata      = '1;

        unique case (uw.run_op)
            RUN_KEEP:  run_next = run_reg;
            RUN_DIGIT: run_next = (prod > PROD_W'(RUN_MAX)) ? RUN_MAX : run_reg;
            RUN_CLEAR: run_next = '0;
            default:   run_next = run_reg;
        endcase
        if ((uw.run_op == RUN_DIGIT) && (prod <= PROD_W'(RUN_MAX)))
        begin
            run_next = prod[RUN_W-1:0];
        end

        unique case (uw.pos_op)
            POS_KEEP:    pos_next = pos_reg;
            POS_ADVANCE: pos_next = pos_adv;
            POS_INC:     pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
            POS_CLEAR:   pos_next = '0;
            default:     pos_next = pos_reg;
        endcase

        if (uw.flush_init)
        begin
            addr_next = ADDR_W'(pos_reg);
            left_next = flush_len;
        end

        if (uw.rec_inc && (rec_reg != CNT_MAX))
        begin
            rec_next = rec_reg + 1'b1;
        end

        unique case (uw.mem_op)
            MEM_IDLE:
            begin
                mem_re = 1'b0;
            end
            MEM_RD_QUERY:
            begin
                mem_re    = 1'b1;
                mem_raddr = ADDR_W'(query_reg);
            end
            MEM_RD_ADDR:
            begin
                mem_re = 1'b1;
            end
            MEM_WR_INC:
            begin
                mem_we = 1'b1;
                if (!rvalid_reg)
                begin
                    mem_wdata = CNT_W'(1);
                end
                else if (mem_rdata != CNT_MAX)
                begin
                    mem_wdata = mem_rdata + 1'b1;
                end
                else
                begin
                    mem_wdata = mem_rdata;
                end
                valid_next[addr_reg] = 1'b1;
                addr_next            = addr_reg + 1'b1;
                left_next            = left_reg - 1'b1;
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (uw.out_load && out_free)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= S_WAIT;
            run_reg       <= '0;
            pos_reg       <= '0;
            rec_reg       <= '0;
            addr_reg      <= '0;
            left_reg      <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            run_reg       <= run_next;
            pos_reg       <= pos_next;
            rec_reg       <= rec_next;
            addr_reg      <= addr_next;
            left_reg      <= left_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg  <= req.md_char;
            eot_reg   <= req.end_of_tag;
            query_reg <= req.query_position;
        end
        if (mem_re)
        begin
            rvalid_reg <= valid_reg[mem_raddr]
                       && ((uw.mem_op != MEM_RD_QUERY) || qry_ok);
        end
        if (uw.out_load && out_free)
        begin
            out_count_reg <= rvalid_reg ? mem_rdata : '0;
            out_total_reg <= rec_reg;
        end
    end

    mdh_ram #(
        .WIDTH (CNT_W),
        .DEPTH (READ_LEN)
    ) u_counts (
        .clk   (clk),
        .we    (mem_we),
        .waddr (addr_reg),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

// File: rtl/core/mdh_checker.sv
// Port-level assertions for the MD tag histogram and their binding to the top level.
`include "assert_macros.svh"

module mdh_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_ready,
    input logic                       req_action,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic [mdh_pkg::CNT_W-1:0]  rsp_position_count,
    input logic [mdh_pkg::CNT_W-1:0]  rsp_record_total
);

    import mdh_pkg::*;

    // A stalled response item stays offered.
    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)

    // A stalled response item keeps its fields.
    `ASSERT_NEXT(a_rsp_stable, clk, rst_n, rsp_valid && !rsp_ready, $stable(rsp_position_count) && $stable(rsp_record_total))

    // The block is not ready in the cycle after it takes an item.
    `ASSERT_NEXT(a_busy_after_item, clk, rst_n, req_valid && req_ready, !req_ready)

    // A fresh response must follow a readout that was taken earlier.
    `ASSERT_IMPLIES(a_rsp_latency, clk, rst_n, $rose(rsp_valid), $past(req_valid && req_ready && req_action, 3))

endmodule

bind md_tag_match_histogram_core mdh_checker u_mdh_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .req_action         (req.action),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_position_count (rsp.position_count),
    .rsp_record_total   (rsp.record_total)
);
